// ----- hdl/cfdr_pkg.sv -----
// Shared types, constants and helpers of the CAN frame dispatch and reassembly block.
package cfdr_pkg;

    localparam int MAX_ENTRIES_DEF = 160;
    localparam int REPLY_SLOTS     = 16;
    localparam logic [15:0] LED_THRESHOLD_RESET = 16'd15000;

    localparam logic [3:0] STD_TYPE_LIGHT = 4'd0;
    localparam logic [3:0] STD_TYPE_REPLY = 4'd1;
    localparam logic [3:0] STD_TYPE_FLAGS = 4'd3;
    localparam logic [2:0] EXT_TYPE_TABLE = 3'd2;
    localparam logic [1:0] LIGHT_PART_1   = 2'd1;
    localparam logic [1:0] LIGHT_PART_2   = 2'd2;

    localparam logic [1:0] TBL_LIGHT = 2'd0;
    localparam logic [1:0] TBL_REPLY = 2'd1;
    localparam logic [1:0] TBL_LIVE  = 2'd2;

    localparam logic [4:0] OFF_FIRST_TAG   = 5'd16;
    localparam logic [4:0] OFF_SECOND_TAG  = 5'd17;
    localparam logic [4:0] OFF_REPLY_VALID = 5'd8;

    localparam logic [3:0] EV_LIGHT1     = 4'd0;
    localparam logic [3:0] EV_LIGHT2     = 4'd1;
    localparam logic [3:0] EV_REPLY      = 4'd2;
    localparam logic [3:0] EV_FLAGS      = 4'd3;
    localparam logic [3:0] EV_HDR_OK     = 4'd4;
    localparam logic [3:0] EV_HDR_REJECT = 4'd5;
    localparam logic [3:0] EV_DATA       = 4'd6;
    localparam logic [3:0] EV_COMMIT     = 4'd7;
    localparam logic [3:0] EV_MISMATCH   = 4'd8;
    localparam logic [3:0] EV_IGNORED    = 4'd9;
    localparam logic [3:0] EV_READ       = 4'd10;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SUM,
        ST_SUM_DRAIN,
        ST_CHECK,
        ST_COPY,
        ST_COPY_DRAIN,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic clr_step;
        logic sum_rd;
        logic check;
        logic copy_rd;
        logic rd_live;
        logic deliver;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic sum_last;
        logic words_zero;
        logic need_commit;
        logic need_live;
        logic sum_match;
    } dp_stat_t;

    function automatic logic [7:0] byte_sel(input logic [63:0] w, input logic [2:0] k);
        return w[{k, 3'b000} +: 8];
    endfunction

    function automatic logic [10:0] byte_sum(input logic [63:0] w);
        logic [10:0] s;
        s = '0;
        for (int i = 0; i < 8; i++)
        begin
            s = s + 11'(w[i*8 +: 8]);
        end
        return s;
    endfunction

endpackage

// ----- hdl/cfdr_if.sv -----
// Channel interfaces: input items, result items and the threshold write channel.
interface cfdr_item_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic        extended;
    logic [28:0] frame_id;
    logic [63:0] payload;
    logic [15:0] timer_count;
    logic [1:0]  read_table;
    logic [7:0]  read_index;
    logic [4:0]  read_offset;

    modport source (output valid, command, extended, frame_id, payload, timer_count,
                    read_table, read_index, read_offset, input ready);
    modport sink (input valid, command, extended, frame_id, payload, timer_count,
                  read_table, read_index, read_offset, output ready);
endinterface

interface cfdr_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic       led_on;
    logic [4:0] tag;
    logic       light_ready;
    logic [4:0] mode_flags;
    logic [7:0] committed_count;
    logic [7:0] read_byte;

    modport source (output valid, event_res, led_on, tag, light_ready, mode_flags,
                    committed_count, read_byte, input ready);
    modport sink (input valid, event_res, led_on, tag, light_ready, mode_flags,
                  committed_count, read_byte, output ready);
endinterface

interface cfdr_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- hdl/cfdr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cfdr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 320
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/cfdr_ctrl.sv -----
// Sequencing state machine: clearing pass, item execution, checksum and commit copy.
module cfdr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    output logic               result_valid,
    input  logic               result_ready,
    output cfdr_pkg::dp_cmd_t  cmd,
    input  cfdr_pkg::dp_stat_t stat
);
    import cfdr_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free    = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign item_ready   = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !result_ready;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.need_commit)
                begin
                    state_next = stat.words_zero ? ST_CHECK : ST_SUM;
                end
                else if (stat.need_live)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SUM:
            begin
                cmd.sum_rd = 1'b1;
                if (stat.sum_last)
                begin
                    state_next = ST_SUM_DRAIN;
                end
            end
            ST_SUM_DRAIN:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = (stat.sum_match && !stat.words_zero) ? ST_COPY : ST_DONE;
            end
            ST_COPY:
            begin
                cmd.copy_rd = 1'b1;
                if (stat.sum_last)
                begin
                    state_next = ST_COPY_DRAIN;
                end
            end
            ST_COPY_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_READ:
            begin
                cmd.rd_live = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.deliver    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ----- hdl/cfdr_dp.sv -----
// Datapath: item registers, dispatch state, staged and live tables, sum and result registers.
module cfdr_dp #(
    parameter int MAX_ENTRIES = cfdr_pkg::MAX_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    cfdr_item_if.sink          item,
    cfdr_result_if.source      result,
    cfdr_cfg_if.sink           cfg,
    input  cfdr_pkg::dp_cmd_t  cmd,
    output cfdr_pkg::dp_stat_t stat
);
    import cfdr_pkg::*;

    localparam int DEPTH = 2 * MAX_ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(MAX_ENTRIES + 1);
    localparam int WW    = CNTW + 1;

    // latched item
    logic        command_reg, extended_reg;
    logic [28:0] id_reg;
    logic [63:0] payload_reg;
    logic [15:0] timer_reg;
    logic [1:0]  table_reg;
    logic [7:0]  index_reg;
    logic [4:0]  offset_reg;

    // block state
    logic [15:0]     threshold_reg;
    logic [63:0]     light_lo_reg, light_hi_reg;
    logic            light_flag_reg;
    logic [4:0]      first_tag_reg, second_tag_reg;
    logic [15:0]     reply_valid_reg;
    logic [63:0]     reply_mem [REPLY_SLOTS];
    logic [4:0]      flags_reg;
    logic [31:0]     expected_sum_reg;
    logic [CNTW-1:0] entry_count_reg, live_count_reg;
    logic [15:0]     frame_total_reg;

    // sequencing
    logic [AW-1:0] cnt_reg;
    logic [31:0]   sum_reg;
    logic          acc_v_reg, copy_v_reg;
    logic [AW-1:0] copy_addr_reg;

    // working result
    logic [3:0] ev_reg;
    logic       led_reg;
    logic [4:0] tag_reg;
    logic [7:0] rd_reg;

    logic [3:0] ev_next;
    logic       led_next;
    logic [4:0] tag_next;
    logic [7:0] rd_next;

    // delivered result
    logic [3:0] out_ev_reg;
    logic       out_led_reg;
    logic [4:0] out_tag_reg;
    logic       out_light_reg;
    logic [4:0] out_flags_reg;
    logic [7:0] out_count_reg;
    logic [7:0] out_rd_reg;

    // decode
    logic [10:0] sid;
    logic [3:0]  std_type;
    logic [1:0]  part;
    logic [3:0]  slot;
    logic [2:0]  ext_type;
    logic [24:0] num, num_m1;
    logic        is_std, is_ext_tbl, is_hdr, is_data, data_in_cap;
    logic        hdr_ok;
    logic [WW-1:0] words;
    logic        live_in_range;
    logic [8:0]  live_word;

    logic [63:0] staged_rdata, live_rdata;
    logic        staged_we, live_we;
    logic [AW-1:0] staged_waddr, live_waddr;
    logic [63:0] staged_wdata, live_wdata;

    assign sid      = id_reg[10:0];
    assign std_type = sid[10:7];
    assign part     = sid[6:5];
    assign slot     = sid[6:3];
    assign ext_type = id_reg[27:25];
    assign num      = id_reg[24:0];
    assign num_m1   = num - 25'd1;

    assign is_std      = !command_reg && !extended_reg;
    assign is_ext_tbl  = !command_reg && extended_reg && (ext_type == EXT_TYPE_TABLE);
    assign is_hdr      = is_ext_tbl && (num == '0);
    assign is_data     = is_ext_tbl && (num != '0) && (num <= {9'd0, frame_total_reg});
    assign data_in_cap = num_m1 < 25'(DEPTH);
    assign hdr_ok      = payload_reg[47:32] <= 16'(MAX_ENTRIES);
    assign words       = {entry_count_reg, 1'b0};

    assign live_word     = {index_reg, offset_reg[3]};
    assign live_in_range = ({1'b0, index_reg} < 9'(MAX_ENTRIES)) && (offset_reg < 5'd16);

    assign stat.clr_last    = (WW'(cnt_reg) + WW'(1)) == WW'(DEPTH);
    assign stat.sum_last    = (WW'(cnt_reg) + WW'(1)) == words;
    assign stat.words_zero  = (entry_count_reg == '0);
    assign stat.need_commit = is_data && (num == {9'd0, frame_total_reg});
    assign stat.need_live   = command_reg && (table_reg == TBL_LIVE) && live_in_range;
    assign stat.sum_match   = (sum_reg == expected_sum_reg);

    assign cfg.ready = 1'b1;

    // memories
    assign staged_we    = cmd.clr_step || (cmd.exec && is_data && data_in_cap);
    assign staged_waddr = cmd.clr_step ? cnt_reg : num_m1[AW-1:0];
    assign staged_wdata = cmd.clr_step ? '0 : payload_reg;
    assign live_we      = cmd.clr_step || copy_v_reg;
    assign live_waddr   = cmd.clr_step ? cnt_reg : copy_addr_reg;
    assign live_wdata   = cmd.clr_step ? '0 : staged_rdata;

    cfdr_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_staged (
        .clk   (clk),
        .we    (staged_we),
        .waddr (staged_waddr),
        .wdata (staged_wdata),
        .raddr (cnt_reg),
        .rdata (staged_rdata)
    );

    cfdr_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_live (
        .clk   (clk),
        .we    (live_we),
        .waddr (live_waddr),
        .wdata (live_wdata),
        .raddr (live_word[AW-1:0]),
        .rdata (live_rdata)
    );

    // item execution: event, LED, tag and direct reads
    always_comb
    begin
        ev_next  = EV_IGNORED;
        led_next = 1'b0;
        tag_next = '0;
        rd_next  = '0;
        if (command_reg)
        begin
            ev_next = EV_READ;
            case (table_reg)
                TBL_LIGHT:
                begin
                    if (offset_reg < 5'd16)
                    begin
                        rd_next = byte_sel(offset_reg[3] ? light_hi_reg : light_lo_reg,
                                           offset_reg[2:0]);
                    end
                    else if (offset_reg == OFF_FIRST_TAG)
                    begin
                        rd_next = {3'd0, first_tag_reg};
                    end
                    else if (offset_reg == OFF_SECOND_TAG)
                    begin
                        rd_next = {3'd0, second_tag_reg};
                    end
                end
                TBL_REPLY:
                begin
                    if (index_reg < 8'(REPLY_SLOTS))
                    begin
                        if (offset_reg < 5'd8)
                        begin
                            if (reply_valid_reg[index_reg[3:0]])
                            begin
                                rd_next = byte_sel(reply_mem[index_reg[3:0]],
                                                   offset_reg[2:0]);
                            end
                        end
                        else if (offset_reg == OFF_REPLY_VALID)
                        begin
                            rd_next = {7'd0, reply_valid_reg[index_reg[3:0]]};
                        end
                    end
                end
                default:
                begin
                    rd_next = '0;
                end
            endcase
        end
        else if (!extended_reg)
        begin
            led_next = (timer_reg >= threshold_reg) || (std_type == STD_TYPE_LIGHT);
            tag_next = sid[4:0];
            case (std_type)
                STD_TYPE_LIGHT:
                begin
                    if (part == LIGHT_PART_2)
                    begin
                        ev_next = EV_LIGHT2;
                    end
                    else if (part == LIGHT_PART_1)
                    begin
                        ev_next = EV_LIGHT1;
                    end
                end
                STD_TYPE_REPLY:
                begin
                    ev_next  = EV_REPLY;
                    tag_next = {1'b0, slot};
                end
                STD_TYPE_FLAGS:
                begin
                    ev_next = EV_FLAGS;
                end
                default:
                begin
                    ev_next = EV_IGNORED;
                end
            endcase
        end
        else if (is_hdr)
        begin
            ev_next = hdr_ok ? EV_HDR_OK : EV_HDR_REJECT;
        end
        else if (is_data && data_in_cap)
        begin
            ev_next = EV_DATA;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg  <= item.command;
            extended_reg <= item.extended;
            id_reg       <= item.frame_id;
            payload_reg  <= item.payload;
            timer_reg    <= item.timer_count;
            table_reg    <= item.read_table;
            index_reg    <= item.read_index;
            offset_reg   <= item.read_offset;
        end
        if (cmd.exec && is_std && (std_type == STD_TYPE_REPLY))
        begin
            reply_mem[slot] <= payload_reg;
        end
        if (cmd.exec)
        begin
            ev_reg  <= ev_next;
            led_reg <= led_next;
            tag_reg <= tag_next;
            rd_reg  <= rd_next;
        end
        else if (cmd.check)
        begin
            ev_reg <= stat.sum_match ? EV_COMMIT : EV_MISMATCH;
        end
        else if (cmd.rd_live)
        begin
            rd_reg <= byte_sel(live_rdata, offset_reg[2:0]);
        end
        copy_addr_reg <= cnt_reg;
        if (cmd.deliver)
        begin
            out_ev_reg    <= ev_reg;
            out_led_reg   <= led_reg;
            out_tag_reg   <= tag_reg;
            out_light_reg <= light_flag_reg;
            out_flags_reg <= flags_reg;
            out_count_reg <= 8'(live_count_reg);
            out_rd_reg    <= rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= LED_THRESHOLD_RESET;
            light_lo_reg     <= '0;
            light_hi_reg     <= '0;
            light_flag_reg   <= 1'b0;
            first_tag_reg    <= '0;
            second_tag_reg   <= '0;
            reply_valid_reg  <= '0;
            flags_reg        <= '0;
            expected_sum_reg <= '0;
            entry_count_reg  <= '0;
            frame_total_reg  <= '0;
            live_count_reg   <= '0;
            cnt_reg          <= '0;
            sum_reg          <= '0;
            acc_v_reg        <= 1'b0;
            copy_v_reg       <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                threshold_reg <= cfg.data;
            end
            acc_v_reg  <= cmd.sum_rd;
            copy_v_reg <= cmd.copy_rd;

            if (cmd.exec)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.clr_step || cmd.sum_rd || cmd.copy_rd)
            begin
                cnt_reg <= cnt_reg + AW'(1);
            end
            else if (cmd.check)
            begin
                cnt_reg <= '0;
            end

            if (cmd.exec)
            begin
                sum_reg <= '0;
            end
            else if (acc_v_reg)
            begin
                sum_reg <= sum_reg + 32'(byte_sum(staged_rdata));
            end

            if (cmd.check && stat.sum_match)
            begin
                live_count_reg <= entry_count_reg;
            end

            if (cmd.exec && is_std)
            begin
                case (std_type)
                    STD_TYPE_LIGHT:
                    begin
                        if (part == LIGHT_PART_2)
                        begin
                            light_hi_reg   <= payload_reg;
                            light_flag_reg <= 1'b1;
                            second_tag_reg <= sid[4:0];
                        end
                        else if (part == LIGHT_PART_1)
                        begin
                            light_lo_reg  <= payload_reg;
                            first_tag_reg <= sid[4:0];
                        end
                    end
                    STD_TYPE_REPLY:
                    begin
                        reply_valid_reg[slot] <= 1'b1;
                    end
                    STD_TYPE_FLAGS:
                    begin
                        flags_reg <= sid[6:2];
                    end
                    default:
                    begin
                        flags_reg <= flags_reg;
                    end
                endcase
            end

            if (cmd.exec && is_hdr)
            begin
                expected_sum_reg <= payload_reg[31:0];
                if (hdr_ok)
                begin
                    entry_count_reg <= payload_reg[32 +: CNTW];
                    frame_total_reg <= payload_reg[63:48];
                end
                else
                begin
                    entry_count_reg <= '0;
                    frame_total_reg <= '0;
                end
            end
        end
    end

    assign result.event_res       = out_ev_reg;
    assign result.led_on          = out_led_reg;
    assign result.tag             = out_tag_reg;
    assign result.light_ready     = out_light_reg;
    assign result.mode_flags      = out_flags_reg;
    assign result.committed_count = out_count_reg;
    assign result.read_byte       = out_rd_reg;
endmodule

// ----- hdl/can_frame_dispatch_reassembly.sv -----
// CAN frame dispatch and takeover table reassembly, top level.
// Takes one beat at a time: a received frame or a byte read. A live table
// read also reads the live RAM before its result is ready. The last data
// frame of a table starts a checksum pass over the staged RAM, one 8-byte
// word a cycle (2 x entry count words), and on a match a copy pass of the same
// length into the live RAM. After reset a clearing pass over all 2 x MAX_ENTRIES
// words zeroes both RAMs before the first item is taken; threshold writes are
// accepted at any time. A finished result sits in an output register, so the
// next item is taken while it waits.
module can_frame_dispatch_reassembly #(
    parameter int MAX_ENTRIES = cfdr_pkg::MAX_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    cfdr_item_if.sink     item,
    cfdr_result_if.source result,
    cfdr_cfg_if.sink      cfg
);
    import cfdr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    cfdr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .stat         (stat)
    );

    cfdr_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg),
        .cmd    (cmd),
        .stat   (stat)
    );
endmodule
